// File: rtl/reverse_mirror_tilt_sequencer_top_macros.svh
// Assertion macros shared by the sequencer checker.
`ifndef REVERSE_MIRROR_TILT_SEQUENCER_TOP_MACROS_SVH
`define REVERSE_MIRROR_TILT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define RMTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmts assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define RMTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmts assertion failed");

`endif

// File: rtl/rmts_pkg.sv
// Package with the types and constants of the mirror tilt sequencer.
package rmts_pkg;

	localparam int unsigned CountW = 16;

	localparam logic [CountW-1:0] DownTicksRst = 16'd3000;
	localparam logic [CountW-1:0] UpTicksRst   = 16'd3000;
	localparam logic [CountW-1:0] HoldTicksRst = 16'd10000;

	typedef enum logic [1:0] {
		PH_NORMAL   = 2'd0,
		PH_LOWERING = 2'd1,
		PH_LOWERED  = 2'd2,
		PH_RAISING  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_DOWN_TICKS      = 2'd0,
		REG_UP_TICKS        = 2'd1,
		REG_HOLD_TICKS      = 2'd2,
		REG_MODEL_SUPPORTED = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CountW-1:0] down_ticks;
		logic [CountW-1:0] up_ticks;
		logic [CountW-1:0] hold_ticks;
		logic              model_supported;
	} cfg_t;

	typedef struct packed {
		logic   relay_enable;
		logic   left_tilt_high;
		logic   left_tilt_low;
		logic   right_tilt_high;
		logic   right_tilt_low;
		logic   common_high;
		logic   common_low;
		phase_t phase;
	} result_t;

endpackage

// File: rtl/rmts_cfg.sv
// Configuration register file of the mirror tilt sequencer.
module rmts_cfg import rmts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [CountW-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.down_ticks      <= DownTicksRst;
			cfg_q.up_ticks        <= UpTicksRst;
			cfg_q.hold_ticks      <= HoldTicksRst;
			cfg_q.model_supported <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_DOWN_TICKS:      cfg_q.down_ticks      <= wr_data;
				REG_UP_TICKS:        cfg_q.up_ticks        <= wr_data;
				REG_HOLD_TICKS:      cfg_q.hold_ticks      <= wr_data;
				REG_MODEL_SUPPORTED: cfg_q.model_supported <= wr_data[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/rmts_fsm.sv
// Phase state machine with the motion and hold counters of the sequencer.
module rmts_fsm import rmts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  logic    rev,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] motion_q, motion_d;
	logic [CountW-1:0] hold_q, hold_d;
	logic              motion_done;
	logic              lowering, raising;

	assign motion_done = (motion_q <= CountW'(1));

	always_comb begin
		phase_d  = phase_q;
		motion_d = motion_q;
		hold_d   = hold_q;
		unique case (phase_q)
			PH_NORMAL: begin
				if (rev) begin
					hold_d = cfg.hold_ticks;
					motion_d = cfg.down_ticks;
					if (cfg.down_ticks == '0) begin
						phase_d = PH_LOWERED;
					end else begin
						phase_d = PH_LOWERING;
					end
				end
			end
			PH_LOWERING: begin
				if (motion_done) begin
					motion_d = '0;
					hold_d   = cfg.hold_ticks;
					phase_d  = PH_LOWERED;
				end else begin
					motion_d = motion_q - CountW'(1);
				end
			end
			PH_LOWERED: begin
				priority if (rev) begin
					hold_d = cfg.hold_ticks;
				end else if (hold_q == '0) begin
					motion_d = cfg.up_ticks;
					if (cfg.up_ticks == '0) begin
						phase_d = PH_NORMAL;
					end else begin
						phase_d = PH_RAISING;
					end
				end else begin
					hold_d = hold_q - CountW'(1);
				end
			end
			PH_RAISING: begin
				if (motion_done) begin
					motion_d = '0;
					phase_d  = PH_NORMAL;
				end else begin
					motion_d = motion_q - CountW'(1);
				end
			end
		endcase
	end

	always_comb begin
		lowering            = (phase_d == PH_LOWERING) && cfg.model_supported;
		raising             = (phase_d == PH_RAISING) && cfg.model_supported;
		res.relay_enable    = (phase_d != PH_NORMAL);
		res.left_tilt_high  = raising;
		res.left_tilt_low   = lowering;
		res.right_tilt_high = raising;
		res.right_tilt_low  = lowering;
		res.common_high     = lowering;
		res.common_low      = raising;
		res.phase           = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			motion_q <= '0;
			hold_q   <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			motion_q <= motion_d;
			hold_q   <= hold_d;
		end
	end

endmodule

// File: rtl/reverse_mirror_tilt_sequencer_top.sv
// Top level of the reverse-gear mirror tilt sequencer.
//
//   channel  handshake            payload
//   in       in_valid / in_stall   reverse_active
//   out      out_valid / out_stall relay_enable, six bridge pins, phase
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick is registered at its transfer and its result when the output stage loads,
// so one tick is taken in every cycle while the output does not stall.
// The combinational phase and counter update between the two registers sets that rate.
// Reset clears the phase, both counters and the valid flags, and loads the register defaults.
// A stall on the output holds the result and backs up into the input stage.
// The configuration port is always ready.
module reverse_mirror_tilt_sequencer_top import rmts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              reverse_active,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              relay_enable,
	output logic              left_tilt_high,
	output logic              left_tilt_low,
	output logic              right_tilt_high,
	output logic              right_tilt_low,
	output logic              common_high,
	output logic              common_low,
	output logic [1:0]        phase,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CountW-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic    rev_s1;
	logic    load_s2, load_s1;

	assign cfg_ready = 1'b1;

	rmts_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	rmts_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (load_s2),
		.rev     (rev_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			rev_s1 <= reverse_active;
		end
		if (load_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign relay_enable    = res_s2.relay_enable;
	assign left_tilt_high  = res_s2.left_tilt_high;
	assign left_tilt_low   = res_s2.left_tilt_low;
	assign right_tilt_high = res_s2.right_tilt_high;
	assign right_tilt_low  = res_s2.right_tilt_low;
	assign common_high     = res_s2.common_high;
	assign common_low      = res_s2.common_low;
	assign phase           = res_s2.phase;

endmodule

// File: rtl/rmts_checker.sv
// Port-level checker of the sequencer and its bind to the top level.
`include "reverse_mirror_tilt_sequencer_top_macros.svh"

module rmts_checker import rmts_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       relay_enable,
	input logic       left_tilt_high,
	input logic       left_tilt_low,
	input logic       right_tilt_high,
	input logic       right_tilt_low,
	input logic       common_high,
	input logic       common_low,
	input logic [1:0] phase
);

	logic low_any, high_any;
	logic low_all, high_all;
	logic pins_lowering, pins_raising;
	logic out_normal;

	assign low_any       = left_tilt_low || right_tilt_low || common_high;
	assign high_any      = left_tilt_high || right_tilt_high || common_low;
	assign low_all       = left_tilt_low && right_tilt_low && common_high;
	assign high_all      = left_tilt_high && right_tilt_high && common_low;
	assign pins_lowering = (phase == PH_LOWERING) && low_all && !high_any;
	assign pins_raising  = (phase == PH_RAISING) && high_all && !low_any;
	assign out_normal    = out_valid && !out_stall && (phase == PH_NORMAL);

	// A stalled result stays valid and keeps its phase.
	`RMTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(phase))

	// The relay is on in every phase but normal.
	`RMTS_ASSERT_NOW(a_relay_phase, out_valid, relay_enable == (phase != PH_NORMAL))

	// Lowering pins are driven only in the lowering phase, raising pins only when raising.
	`RMTS_ASSERT_NOW(a_pins_phase, out_valid && (low_any || high_any), pins_lowering || pins_raising)

	// The normal phase never goes straight to raising.
	`RMTS_ASSERT_NOW(a_no_skip, out_normal ##1 out_valid, phase != PH_RAISING)

endmodule

bind reverse_mirror_tilt_sequencer_top rmts_checker u_rmts_checker (.*);

// File: bench/tilt_sequence_checker.sv
// Checker that predicts the sequencer results from observed transfers and compares them.
module tilt_sequence_checker import rmts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              reverse_active,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              relay_enable,
	input  logic              left_tilt_high,
	input  logic              left_tilt_low,
	input  logic              right_tilt_high,
	input  logic              right_tilt_low,
	input  logic              common_high,
	input  logic              common_low,
	input  logic [1:0]        phase,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CountW-1:0] cfg_data,
	output int                mismatches,
	output int                expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t              settings;
	phase_t            seq_phase;
	logic [CountW-1:0] motion_left;
	logic [CountW-1:0] hold_left;
	result_t           tilt_expected[$];

	function automatic void begin_raise();
		if (settings.up_ticks == '0) begin
			motion_left = '0;
			seq_phase = PH_NORMAL;
		end else begin
			motion_left = settings.up_ticks;
			seq_phase = PH_RAISING;
		end
	endfunction

	function automatic result_t advance_tilt(logic rev);
		result_t r;
		logic    lowering;
		logic    raising;
		case (seq_phase)
			PH_NORMAL: begin
				if (rev) begin
					hold_left = settings.hold_ticks;
					if (settings.down_ticks == '0) begin
						motion_left = '0;
						seq_phase = PH_LOWERED;
					end else begin
						motion_left = settings.down_ticks;
						seq_phase = PH_LOWERING;
					end
				end
			end
			PH_LOWERING: begin
				if (motion_left <= 16'd1) begin
					motion_left = '0;
					hold_left = settings.hold_ticks;
					seq_phase = PH_LOWERED;
				end else begin
					motion_left = motion_left - 16'd1;
				end
			end
			PH_LOWERED: begin
				if (rev) begin
					hold_left = settings.hold_ticks;
				end else if (hold_left == '0) begin
					begin_raise();
				end else begin
					hold_left = hold_left - 16'd1;
				end
			end
			default: begin
				if (motion_left <= 16'd1) begin
					motion_left = '0;
					seq_phase = PH_NORMAL;
				end else begin
					motion_left = motion_left - 16'd1;
				end
			end
		endcase
		lowering = (seq_phase == PH_LOWERING) && settings.model_supported;
		raising = (seq_phase == PH_RAISING) && settings.model_supported;
		r.relay_enable = (seq_phase != PH_NORMAL);
		r.left_tilt_high = raising;
		r.left_tilt_low = lowering;
		r.right_tilt_high = raising;
		r.right_tilt_low = lowering;
		r.common_high = lowering;
		r.common_low = raising;
		r.phase = seq_phase;
		return r;
	endfunction

	task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			settings = '{down_ticks: DownTicksRst, up_ticks: UpTicksRst,
				hold_ticks: HoldTicksRst, model_supported: 1'b1};
			seq_phase = PH_NORMAL;
			motion_left = '0;
			hold_left = '0;
			tilt_expected.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tilt_expected.size() == 0) begin
					mismatches++;
					$display("%0t ns: result expected none, actual phase %0d", $time, phase);
				end else begin
					want = tilt_expected.pop_front();
					check_field("relay_enable", 2'(want.relay_enable), 2'(relay_enable));
					check_field("left_tilt_high", 2'(want.left_tilt_high), 2'(left_tilt_high));
					check_field("left_tilt_low", 2'(want.left_tilt_low), 2'(left_tilt_low));
					check_field("right_tilt_high", 2'(want.right_tilt_high),
						2'(right_tilt_high));
					check_field("right_tilt_low", 2'(want.right_tilt_low), 2'(right_tilt_low));
					check_field("common_high", 2'(want.common_high), 2'(common_high));
					check_field("common_low", 2'(want.common_low), 2'(common_low));
					check_field("phase", want.phase, phase);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DOWN_TICKS:      settings.down_ticks = cfg_data;
					REG_UP_TICKS:        settings.up_ticks = cfg_data;
					REG_HOLD_TICKS:      settings.hold_ticks = cfg_data;
					REG_MODEL_SUPPORTED: settings.model_supported = cfg_data[0];
				endcase
			end
			if (in_valid && !in_stall) begin
				tilt_expected.push_back(advance_tilt(reverse_active));
			end
		end
		expected_left = tilt_expected.size();
	end

endmodule

// File: bench/testbench.sv
// Top of the sequencer bench: clock, reset, tick and register stimulus, and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rmts_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              reverse_active;
	logic              out_valid;
	logic              out_stall;
	logic              relay_enable;
	logic              left_tilt_high;
	logic              left_tilt_low;
	logic              right_tilt_high;
	logic              right_tilt_low;
	logic              common_high;
	logic              common_low;
	logic [1:0]        phase;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [CountW-1:0] cfg_data;
	int                mismatches;
	int                expected_left;

	logic        tick_taken;
	logic        write_taken;
	int          ticks_sent = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	reverse_mirror_tilt_sequencer_top u_dut (.*);

	tilt_sequence_checker u_checker (.*);

	always #6 clk = ~clk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_taken <= 1'b0;
			write_taken <= 1'b0;
		end else begin
			tick_taken <= in_valid && !in_stall;
			write_taken <= cfg_valid && cfg_ready;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= (stall_left % 5 < 2);
		endcase
	end

	task automatic write_reg(cfg_reg_t idx, logic [CountW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!write_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_tick(logic rev);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		reverse_active <= rev;
		do @(negedge clk); while (!tick_taken);
		ticks_sent++;
	endtask

	task automatic push_run(int n, logic [31:0] pattern);
		for (int i = n - 1; i >= 0; i--) push_tick(pattern[i]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CountW-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) return 16'd1;
		if (r == 2) return CountW'($urandom_range(13, 60));
		return CountW'($urandom_range(2, 12));
	endfunction

	task automatic random_settings(bit all_regs);
		if (all_regs || $urandom_range(0, 1)) write_reg(REG_DOWN_TICKS, pick_ticks());
		if (all_regs || $urandom_range(0, 1)) write_reg(REG_UP_TICKS, pick_ticks());
		if (all_regs || $urandom_range(0, 1)) write_reg(REG_HOLD_TICKS, pick_ticks());
		if (all_regs || $urandom_range(0, 1)) write_reg(REG_MODEL_SUPPORTED, CountW'($urandom()));
	endtask

	task automatic run_phase(int n);
		int done;
		int k;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(1, 20);
				repeat (k) push_tick(1'b1);
				done += k;
				k = $urandom_range(1, 40);
				repeat (k) push_tick(1'b0);
				done += k;
			end else begin
				k = $urandom_range(1, 10);
				repeat (k) push_tick(1'($urandom_range(0, 1)));
				done += k;
			end
		end
	endtask

	task automatic hold_extreme_phase();
		write_reg(REG_DOWN_TICKS, 16'd3);
		write_reg(REG_UP_TICKS, 16'd3);
		write_reg(REG_HOLD_TICKS, 16'd2);
		repeat (80) push_tick(1'b1);
		settle();
		write_reg(REG_DOWN_TICKS, 16'hFFFF);
		write_reg(REG_UP_TICKS, 16'hFFFF);
		write_reg(REG_HOLD_TICKS, 16'hFFFF);
		write_reg(REG_MODEL_SUPPORTED, 16'h0000);
		push_tick(1'b1);
		repeat (24) push_tick($urandom_range(0, 3) != 0);
		settle();
		write_reg(REG_DOWN_TICKS, 16'd7);
		write_reg(REG_UP_TICKS, 16'd2);
		write_reg(REG_HOLD_TICKS, 16'd4);
		write_reg(REG_MODEL_SUPPORTED, 16'hFFFF);
	endtask

	initial begin
		#2_000_000;
		$display("reverse_mirror_tilt_sequencer_top test failed");
		$finish;
	end

	initial begin
		int phase_no;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		reverse_active = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DOWN_TICKS;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_DOWN_TICKS, 16'd2);
		write_reg(REG_UP_TICKS, 16'd1);
		write_reg(REG_HOLD_TICKS, 16'd1);
		write_reg(REG_MODEL_SUPPORTED, 16'd1);
		push_run(8, 32'b0101_1001);
		settle();
		write_reg(REG_DOWN_TICKS, 16'd0);
		write_reg(REG_UP_TICKS, 16'd0);
		write_reg(REG_HOLD_TICKS, 16'd0);
		write_reg(REG_MODEL_SUPPORTED, 16'hFFFE);
		push_run(5, 32'b10110);
		settle();
		write_reg(REG_DOWN_TICKS, 16'd5);
		write_reg(REG_MODEL_SUPPORTED, 16'h0001);
		push_run(3, 32'b100);
		settle();
		write_reg(REG_MODEL_SUPPORTED, 16'h8000);
		write_reg(REG_DOWN_TICKS, 16'd1);
		push_run(3, 32'b000);
		settle();
		write_reg(REG_MODEL_SUPPORTED, 16'h7FFF);
		push_run(2, 32'b10);
		settle();

		phase_no = 0;
		while (ticks_sent < 1650) begin
			if (phase_no == 6) hold_extreme_phase();
			random_settings(phase_no == 0);
			run_phase($urandom_range(30, 120));
			settle();
			phase_no++;
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("reverse_mirror_tilt_sequencer_top test passed");
		end else begin
			$display("reverse_mirror_tilt_sequencer_top test failed");
		end
		$finish;
	end

endmodule
